// File: hw/rtl/tbla_pkg.sv
// Shared constants, types and helpers of the three band level analyser.
`default_nettype none
package tbla_pkg;

    localparam int SAMPLE_BITS_DEF    = 24;
    localparam int COEF_BITS_DEF      = 21;
    localparam int HOP_COUNT_BITS_DEF = 12;

    // filter delay format: 40 bits, 30 fractional
    localparam int Z_BITS  = 40;
    localparam int Z_FRAC  = 30;
    // headroom for the delay update sums
    localparam int ZX_BITS = Z_BITS + 4;

    localparam int CFG_IDX_BITS = 2;
    localparam int HOP_RESET    = 160;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_LOW  = 2'd0,
        CFG_MID  = 2'd1,
        CFG_HIGH = 2'd2,
        CFG_HOP  = 2'd3
    } t_cfg_idx;

    // clamp a widened sum to the signed delay range
    function automatic logic signed [Z_BITS-1:0] sat_z(input logic signed [ZX_BITS-1:0] v);
        logic signed [ZX_BITS-1:0] hi;
        logic signed [ZX_BITS-1:0] lo;
        hi = ZX_BITS'({(Z_BITS-1){1'b1}});
        lo = -hi - ZX_BITS'(1);
        if (v > hi) begin
            return hi[Z_BITS-1:0];
        end else if (v < lo) begin
            return lo[Z_BITS-1:0];
        end
        return v[Z_BITS-1:0];
    endfunction

endpackage
`default_nettype wire

// File: hw/rtl/tbla_if.sv
// Handshake channels: sample requests, level results and register writes.
`default_nettype none
interface tbla_in_if import tbla_pkg::*; #(parameter int SAMPLE_BITS = SAMPLE_BITS_DEF) ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          flush;
    modport source (output valid, sample, flush, input ready);
    modport sink   (input valid, sample, flush, output ready);
endinterface

interface tbla_out_if import tbla_pkg::*; #(
    parameter int SAMPLE_BITS    = SAMPLE_BITS_DEF,
    parameter int HOP_COUNT_BITS = HOP_COUNT_BITS_DEF
) ();
    logic                      valid;
    logic                      ready;
    logic [SAMPLE_BITS-2:0]    rms_level;
    logic [SAMPLE_BITS-2:0]    low_peak;
    logic [SAMPLE_BITS-2:0]    mid_peak;
    logic [SAMPLE_BITS-2:0]    high_peak;
    logic [HOP_COUNT_BITS-1:0] hop_samples;
    modport source (output valid, rms_level, low_peak, mid_peak, high_peak, hop_samples,
                    input ready);
    modport sink   (input valid, rms_level, low_peak, mid_peak, high_peak, hop_samples,
                    output ready);
endinterface

interface tbla_cfg_if import tbla_pkg::*; #(parameter int DATA_BITS = 3 * COEF_BITS_DEF) ();
    logic                    valid;
    logic                    ready;
    logic [CFG_IDX_BITS-1:0] index;
    logic [DATA_BITS-1:0]    data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/tbla_front.sv
// Front end: takes sample and flush requests into a two entry queue.
`default_nettype none
module tbla_front import tbla_pkg::*; #(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    tbla_in_if.sink                            i_smp,
    output logic                               o_q_valid,
    input  wire logic                          i_q_pop,
    output logic signed [SAMPLE_BITS-1:0]      o_q_sample,
    output logic                               o_q_flush
);

    logic signed [SAMPLE_BITS-1:0] r_sample [2];
    logic                          r_flush  [2];
    logic                          r_wr;
    logic                          r_rd;
    logic [1:0]                    r_cnt;
    logic                          w_push;
    logic                          w_pop;

    assign i_smp.ready = (r_cnt != 2'd2);
    assign w_push      = i_smp.valid && i_smp.ready;
    assign o_q_valid   = (r_cnt != 2'd0);
    assign w_pop       = i_q_pop && o_q_valid;
    assign o_q_sample  = r_sample[r_rd];
    assign o_q_flush   = r_flush[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr <= ~r_wr;
            end
            if (w_pop) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
        if (w_push) begin
            r_sample[r_wr] <= i_smp.sample;
            // a flush carries no sample; keep its class bit with it
            r_flush[r_wr]  <= i_smp.flush;
        end
    end

endmodule
`default_nettype wire

// File: hw/rtl/tbla_back.sv
// Back end: three biquads on one shared multiplier, hop statistics, divide and root.
`default_nettype none
module tbla_back import tbla_pkg::*; #(
    parameter int SAMPLE_BITS    = SAMPLE_BITS_DEF,
    parameter int COEF_BITS      = COEF_BITS_DEF,
    parameter int HOP_COUNT_BITS = HOP_COUNT_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic [3*COEF_BITS-1:0]        i_low_coef,
    input  wire logic [3*COEF_BITS-1:0]        i_mid_coef,
    input  wire logic [3*COEF_BITS-1:0]        i_high_coef,
    input  wire logic [HOP_COUNT_BITS-1:0]     i_hop_len,
    input  wire logic                          i_q_valid,
    output logic                               o_q_pop,
    input  wire logic signed [SAMPLE_BITS-1:0] i_q_sample,
    input  wire logic                          i_q_flush,
    tbla_out_if.source                         o_res
);

    localparam int PW         = SAMPLE_BITS - 1;
    localparam int H          = HOP_COUNT_BITS;
    localparam int C          = COEF_BITS;
    localparam int SQ_W       = 2 * PW + H;
    localparam int RT_W       = (SQ_W + 1) / 2;
    localparam int MA_W       = (SAMPLE_BITS > C) ? SAMPLE_BITS : C;
    localparam int PROD_W     = MA_W + Z_BITS;
    localparam int PROD_SHIFT = SAMPLE_BITS - 1 + C - 3 - Z_FRAC;
    localparam int COEF_FRAC  = C - 3;
    localparam int OUT_SHIFT  = Z_FRAC - (SAMPLE_BITS - 1);
    localparam int YO_W       = Z_BITS + 2;
    localparam int DC_W       = $clog2(SQ_W);
    localparam logic [PW-1:0] PK_MAX = {PW{1'b1}};

    typedef enum logic [3:0] {
        S_IDLE, S_BX, S_Y, S_A1, S_A2, S_UPD, S_SQ, S_ACC, S_DIV, S_ROOT, S_OUT
    } t_state;

    typedef enum logic [1:0] {BAND_LOW, BAND_MID, BAND_HIGH} t_band;

    t_state                     r_state;
    t_band                      r_band;
    logic signed [SAMPLE_BITS-1:0] r_x;
    logic signed [Z_BITS-1:0]   r_bx;
    logic signed [Z_BITS-1:0]   r_y;
    logic signed [ZX_BITS-1:0]  r_ay1;
    logic signed [ZX_BITS-1:0]  r_ay2;
    logic signed [Z_BITS-1:0]   r_z1 [3];
    logic signed [Z_BITS-1:0]   r_z2 [3];
    logic [PW-1:0]              r_pk [3];
    logic [2*PW:0]              r_sq;
    logic [SQ_W-1:0]            r_sum;
    logic [H-1:0]               r_cnt;
    logic [SQ_W-1:0]            r_num;
    logic [H-1:0]               r_rem;
    logic [DC_W-1:0]            r_dcnt;
    logic [SQ_W-1:0]            r_res;
    logic [SQ_W-1:0]            r_bit;
    logic                       r_ovalid;
    logic [PW-1:0]              r_orms;
    logic [PW-1:0]              r_olow;
    logic [PW-1:0]              r_omid;
    logic [PW-1:0]              r_ohigh;
    logic [H-1:0]               r_ocnt;

    logic [3*C-1:0]             w_coef;
    logic signed [MA_W-1:0]     w_ma;
    logic signed [Z_BITS-1:0]   w_mb;
    logic signed [PROD_W-1:0]   w_prod;
    logic signed [ZX_BITS-1:0]  w_bxe;
    logic signed [ZX_BITS-1:0]  w_k1bx;
    logic signed [ZX_BITS-1:0]  w_k2bx;
    logic signed [YO_W-1:0]     w_yext;
    logic signed [YO_W-1:0]     w_yo;
    logic [YO_W-1:0]            w_mag;
    logic [PW-1:0]              w_pk;
    logic [H-1:0]               n_cnt;
    logic [SQ_W-1:0]            n_sum;
    logic [H:0]                 w_dt;
    logic                       w_dge;
    logic [SQ_W-1:0]            w_trial;
    logic                       w_out_free;

    always_comb begin
        case (r_band)
            BAND_LOW: w_coef = i_low_coef;
            BAND_MID: w_coef = i_mid_coef;
            default:  w_coef = i_high_coef;
        endcase
    end

    // shared multiplier operand selection
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        case (r_state)
            S_BX: begin
                w_ma = MA_W'($signed(w_coef[C-1:0]));
                w_mb = Z_BITS'(r_x);
            end
            S_A1: begin
                w_ma = MA_W'($signed(w_coef[2*C-1:C]));
                w_mb = r_y;
            end
            S_A2: begin
                w_ma = MA_W'($signed(w_coef[3*C-1:2*C]));
                w_mb = r_y;
            end
            S_SQ: begin
                w_ma = MA_W'(r_x);
                w_mb = Z_BITS'(r_x);
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    assign w_prod = w_ma * w_mb;

    assign w_bxe = ZX_BITS'(r_bx);
    always_comb begin
        case (r_band)
            BAND_LOW: begin
                w_k1bx = w_bxe <<< 1;
                w_k2bx = w_bxe;
            end
            BAND_MID: begin
                w_k1bx = '0;
                w_k2bx = -w_bxe;
            end
            default: begin
                w_k1bx = -(w_bxe <<< 1);
                w_k2bx = w_bxe;
            end
        endcase
    end

    // band output to sample format, magnitude clamped
    assign w_yext = YO_W'(r_y);
    generate
        if (OUT_SHIFT >= 0) begin : g_out_shr
            assign w_yo = w_yext >>> OUT_SHIFT;
        end else begin : g_out_shl
            assign w_yo = w_yext <<< (-OUT_SHIFT);
        end
    endgenerate
    assign w_mag = w_yo[YO_W-1] ? YO_W'(-w_yo) : YO_W'(w_yo);
    assign w_pk  = (w_mag > YO_W'(PK_MAX)) ? PK_MAX : w_mag[PW-1:0];

    assign n_cnt = r_cnt + H'(1);
    assign n_sum = r_sum + SQ_W'(r_sq);

    assign w_dt    = {r_rem, r_num[SQ_W-1]};
    assign w_dge   = (w_dt >= {1'b0, r_cnt});
    assign w_trial = r_res + r_bit;

    assign w_out_free = !r_ovalid || o_res.ready;
    assign o_q_pop    = (r_state == S_IDLE) && i_q_valid;

    assign o_res.valid       = r_ovalid;
    assign o_res.rms_level   = r_orms;
    assign o_res.low_peak    = r_olow;
    assign o_res.mid_peak    = r_omid;
    assign o_res.high_peak   = r_ohigh;
    assign o_res.hop_samples = r_ocnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_band   <= BAND_LOW;
            r_ovalid <= 1'b0;
            r_sum    <= '0;
            r_cnt    <= '0;
            for (int i = 0; i < 3; i++) begin
                r_z1[i] <= '0;
                r_z2[i] <= '0;
                r_pk[i] <= '0;
            end
        end else begin
            // drop a taken result; the load state sets valid itself
            if (r_ovalid && o_res.ready && r_state != S_OUT) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_x    <= i_q_sample;
                        r_band <= BAND_LOW;
                        r_num  <= r_sum;
                        r_rem  <= '0;
                        r_dcnt <= '0;
                        if (!i_q_flush) begin
                            r_state <= S_BX;
                        end else if (r_cnt != '0) begin
                            r_state <= S_DIV;
                        end
                    end
                end
                S_BX: begin
                    r_bx    <= Z_BITS'(w_prod >>> PROD_SHIFT);
                    r_state <= S_Y;
                end
                S_Y: begin
                    r_y     <= sat_z(w_bxe + ZX_BITS'(r_z1[r_band]));
                    r_state <= S_A1;
                end
                S_A1: begin
                    r_ay1   <= ZX_BITS'(w_prod >>> COEF_FRAC);
                    r_state <= S_A2;
                end
                S_A2: begin
                    r_ay2   <= ZX_BITS'(w_prod >>> COEF_FRAC);
                    r_state <= S_UPD;
                end
                S_UPD: begin
                    r_z1[r_band] <= sat_z(w_k1bx - r_ay1 + ZX_BITS'(r_z2[r_band]));
                    r_z2[r_band] <= sat_z(w_k2bx - r_ay2);
                    if (w_pk > r_pk[r_band]) begin
                        r_pk[r_band] <= w_pk;
                    end
                    if (r_band == BAND_HIGH) begin
                        r_state <= S_SQ;
                    end else begin
                        r_band  <= t_band'(r_band + 2'd1);
                        r_state <= S_BX;
                    end
                end
                S_SQ: begin
                    r_sq    <= w_prod[2*PW:0];
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    r_sum <= n_sum;
                    r_cnt <= n_cnt;
                    r_num <= n_sum;
                    r_rem <= '0;
                    r_dcnt <= '0;
                    // a count that wraps to zero does not close the hop
                    if (n_cnt != '0 && n_cnt >= i_hop_len) begin
                        r_state <= S_DIV;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_DIV: begin
                    r_num  <= {r_num[SQ_W-2:0], w_dge};
                    r_rem  <= w_dge ? H'(w_dt - {1'b0, r_cnt}) : w_dt[H-1:0];
                    r_dcnt <= r_dcnt + DC_W'(1);
                    if (r_dcnt == DC_W'(SQ_W - 1)) begin
                        r_res   <= '0;
                        r_bit   <= SQ_W'(1) << (2 * (RT_W - 1));
                        r_state <= S_ROOT;
                    end
                end
                S_ROOT: begin
                    // r_num now holds the remaining radicand
                    if (r_bit == '0) begin
                        r_state <= S_OUT;
                    end else begin
                        if (r_num >= w_trial) begin
                            r_num <= r_num - w_trial;
                            r_res <= (r_res >> 1) + r_bit;
                        end else begin
                            r_res <= r_res >> 1;
                        end
                        r_bit <= r_bit >> 2;
                    end
                end
                S_OUT: begin
                    if (w_out_free) begin
                        r_ovalid <= 1'b1;
                        r_orms   <= (r_res > SQ_W'(PK_MAX)) ? PK_MAX : r_res[PW-1:0];
                        r_olow   <= r_pk[BAND_LOW];
                        r_omid   <= r_pk[BAND_MID];
                        r_ohigh  <= r_pk[BAND_HIGH];
                        r_ocnt   <= r_cnt;
                        r_sum    <= '0;
                        r_cnt    <= '0;
                        for (int i = 0; i < 3; i++) begin
                            r_pk[i] <= '0;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

// File: hw/rtl/three_band_level_analyzer_unit.sv
// Top level of the three band level analyser: register file, front end, back end.
//
//   channel  dir  handshake        carries
//   i_smp    in   valid / ready    sample, flush
//   i_cfg    in   valid / ready    index, data (register write)
//   o_res    out  valid / ready    rms_level, three peaks, hop_samples
//
// A sample request passes through the back end in steps: one to take it, five per band
// on the one shared multiplier, then square and accumulate. Closing a hop adds a
// restoring divide, the root and one step to load the result, which is held back while
// an earlier result still waits.
// The two entry queue takes requests while the back end works or the result waits, until it is full.
// Reset is synchronous and clears delays, hop statistics and registers; no clearing pass.
// Register writes are always taken.
`default_nettype none
module three_band_level_analyzer_unit import tbla_pkg::*; #(
    parameter int SAMPLE_BITS    = SAMPLE_BITS_DEF,
    parameter int COEF_BITS      = COEF_BITS_DEF,
    parameter int HOP_COUNT_BITS = HOP_COUNT_BITS_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    tbla_in_if.sink    i_smp,
    tbla_cfg_if.sink   i_cfg,
    tbla_out_if.source o_res
);

    logic [3*COEF_BITS-1:0]        r_low_coef;
    logic [3*COEF_BITS-1:0]        r_mid_coef;
    logic [3*COEF_BITS-1:0]        r_high_coef;
    logic [HOP_COUNT_BITS-1:0]     r_hop_len;
    logic                          w_q_valid;
    logic                          w_q_pop;
    logic signed [SAMPLE_BITS-1:0] w_q_sample;
    logic                          w_q_flush;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low_coef  <= '0;
            r_mid_coef  <= '0;
            r_high_coef <= '0;
            r_hop_len   <= HOP_COUNT_BITS'(HOP_RESET);
        end else if (i_cfg.valid) begin
            unique case (t_cfg_idx'(i_cfg.index))
                CFG_LOW:  r_low_coef  <= i_cfg.data[3*COEF_BITS-1:0];
                CFG_MID:  r_mid_coef  <= i_cfg.data[3*COEF_BITS-1:0];
                CFG_HIGH: r_high_coef <= i_cfg.data[3*COEF_BITS-1:0];
                CFG_HOP:  r_hop_len   <= i_cfg.data[HOP_COUNT_BITS-1:0];
                default:  r_hop_len   <= r_hop_len;
            endcase
        end
    end

    tbla_front #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_smp      (i_smp),
        .o_q_valid  (w_q_valid),
        .i_q_pop    (w_q_pop),
        .o_q_sample (w_q_sample),
        .o_q_flush  (w_q_flush)
    );

    tbla_back #(
        .SAMPLE_BITS    (SAMPLE_BITS),
        .COEF_BITS      (COEF_BITS),
        .HOP_COUNT_BITS (HOP_COUNT_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_low_coef  (r_low_coef),
        .i_mid_coef  (r_mid_coef),
        .i_high_coef (r_high_coef),
        .i_hop_len   (r_hop_len),
        .i_q_valid   (w_q_valid),
        .o_q_pop     (w_q_pop),
        .i_q_sample  (w_q_sample),
        .i_q_flush   (w_q_flush),
        .o_res       (o_res)
    );

endmodule
`default_nettype wire

// File: hw/rtl/tbla_checker.sv
// Port level checks of the three band level analyser, bound to the top level.
`default_nettype none
module tbla_checker import tbla_pkg::*; #(
    parameter int HOP_COUNT_BITS = HOP_COUNT_BITS_DEF
) (
    input wire logic                      i_clk,
    input wire logic                      i_rst_n,
    input wire logic                      i_out_valid,
    input wire logic                      i_out_ready,
    input wire logic [HOP_COUNT_BITS-1:0] i_hop_samples,
    input wire logic                      i_cfg_ready
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result shown straight after reset");

    a_hop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_hop_samples != '0)
        else $error("result from an empty hop");

    a_cfg_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_ready)
        else $error("register write refused");

endmodule

bind three_band_level_analyzer_unit tbla_checker #(
    .HOP_COUNT_BITS (HOP_COUNT_BITS)
) u_tbla_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_res.valid),
    .i_out_ready   (o_res.ready),
    .i_hop_samples (o_res.hop_samples),
    .i_cfg_ready   (i_cfg.ready)
);
`default_nettype wire

// File: verif/tbla_level_checker.sv
// Level checker: watches the sample, register and result channels and scores the results.
`timescale 1ns / 1ps
module tbla_level_checker import tbla_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    tbla_in_if        i_smp,
    tbla_cfg_if       i_cfg,
    tbla_out_if       i_res,
    output int        o_fail_count,
    output int        o_pending
);

    localparam longint OUT_LIMIT = 64'd8388607;

    typedef struct packed {
        logic [22:0] rms_level;
        logic [22:0] low_peak;
        logic [22:0] mid_peak;
        logic [22:0] high_peak;
        logic [11:0] hop_samples;
    } level_report_t;

    level_report_t   report_queue[$];
    logic [62:0]     band_coefs[3];
    logic [11:0]     hop_length;
    longint          delay_one[3];
    longint          delay_two[3];
    longint unsigned square_sum;
    logic [22:0]     peak_hold[3];
    logic [11:0]     hop_count;
    int              fail_count;

    assign o_fail_count = fail_count;
    assign o_pending    = report_queue.size();

    function automatic longint clamp_delay(longint v);
        longint hi;
        hi = (64'sd1 <<< 39) - 1;
        if (v > hi) begin
            return hi;
        end else if (v < -hi - 1) begin
            return -hi - 1;
        end
        return v;
    endfunction

    function automatic longint unsigned floor_root(longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v   -= res + bitv;
                res  = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    // band 0 lowpass, 1 bandpass, 2 highpass; returns the saturated output magnitude
    function automatic logic [22:0] filter_band(int band, longint x);
        longint b0, a1, a2, bx, y, mag, k1, k2, next_one;
        b0 = longint'($signed(band_coefs[band][20:0]));
        a1 = longint'($signed(band_coefs[band][41:21]));
        a2 = longint'($signed(band_coefs[band][62:42]));
        k1 = (band == 0) ? 2 : (band == 1) ? 0 : -2;
        k2 = (band == 1) ? -1 : 1;
        bx = (b0 * x) >>> 11;
        y  = clamp_delay(bx + delay_one[band]);
        next_one = clamp_delay(k1 * bx - ((a1 * y) >>> 18) + delay_two[band]);
        delay_two[band] = clamp_delay(k2 * bx - ((a2 * y) >>> 18));
        delay_one[band] = next_one;
        mag = y >>> 7;
        if (mag < 0) mag = -mag;
        if (mag > OUT_LIMIT) mag = OUT_LIMIT;
        return mag[22:0];
    endfunction

    function automatic void close_hop();
        level_report_t   r;
        longint unsigned root;
        root = floor_root(square_sum / hop_count);
        if (root > OUT_LIMIT) root = OUT_LIMIT;
        r.rms_level   = root[22:0];
        r.low_peak    = peak_hold[0];
        r.mid_peak    = peak_hold[1];
        r.high_peak   = peak_hold[2];
        r.hop_samples = hop_count;
        report_queue.push_back(r);
        square_sum = 0;
        hop_count  = 0;
        foreach (peak_hold[b]) peak_hold[b] = '0;
    endfunction

    function automatic void take_sample(logic signed [23:0] s, logic flush);
        longint      x;
        logic [22:0] p;
        if (flush) begin
            if (hop_count != 0) close_hop();
            return;
        end
        x = longint'(s);
        for (int b = 0; b < 3; b++) begin
            p = filter_band(b, x);
            if (p > peak_hold[b]) peak_hold[b] = p;
        end
        square_sum += longint'(x * x);
        hop_count  += 12'd1;
        if (hop_count != 0 && hop_count >= hop_length) close_hop();
    endfunction

    function automatic void check_field(string name, longint want, longint got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        level_report_t want;
        if (!i_rst_n) begin
            report_queue.delete();
            foreach (band_coefs[b]) begin
                band_coefs[b] = '0;
                delay_one[b]  = 0;
                delay_two[b]  = 0;
                peak_hold[b]  = '0;
            end
            hop_length = 12'(HOP_RESET);
            square_sum = 0;
            hop_count  = 0;
        end else begin
            // score before predicting: a result never comes from the request of the same edge
            if (i_res.valid && i_res.ready) begin
                if (report_queue.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual rms %0d hop %0d",
                             $time, i_res.rms_level, i_res.hop_samples);
                    fail_count++;
                end else begin
                    want = report_queue.pop_front();
                    check_field("rms_level", want.rms_level, i_res.rms_level);
                    check_field("low_peak", want.low_peak, i_res.low_peak);
                    check_field("mid_peak", want.mid_peak, i_res.mid_peak);
                    check_field("high_peak", want.high_peak, i_res.high_peak);
                    check_field("hop_samples", want.hop_samples, i_res.hop_samples);
                end
            end
            if (i_cfg.valid && i_cfg.ready) begin
                case (t_cfg_idx'(i_cfg.index))
                    CFG_LOW:  band_coefs[0] = i_cfg.data;
                    CFG_MID:  band_coefs[1] = i_cfg.data;
                    CFG_HIGH: band_coefs[2] = i_cfg.data;
                    CFG_HOP:  hop_length    = i_cfg.data[11:0];
                    default: ;
                endcase
            end
            if (i_smp.valid && i_smp.ready) take_sample(i_smp.sample, i_smp.flush);
        end
    end

    initial fail_count = 0;

    final begin
        if (report_queue.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, report_queue.size());
        end
    end

endmodule

// File: verif/three_band_level_analyzer_unit_tb.sv
// Testbench top: clock, reset, sample and register stimulus, receiver stalls and verdict.
`timescale 1ns / 1ps
module three_band_level_analyzer_unit_tb;
    import tbla_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int SETTLE      = 300;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   cycle_count;
    int   burst_left;
    int   ready_pct;

    tbla_in_if  smp_ch();
    tbla_cfg_if cfg_ch();
    tbla_out_if res_ch();

    three_band_level_analyzer_unit i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_smp   (smp_ch),
        .i_cfg   (cfg_ch),
        .o_res   (res_ch)
    );

    tbla_level_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_smp        (smp_ch),
        .i_cfg        (cfg_ch),
        .i_res        (res_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // receiver: change the stall density now and then, full speed among the choices
    always @(posedge i_clk) begin
        if (cycle_count % 700 == 0) begin
            case ($urandom_range(0, 3))
                0: ready_pct <= 100;
                1: ready_pct <= 75;
                2: ready_pct <= 30;
                default: ready_pct <= 5;
            endcase
        end
        res_ch.ready <= ($urandom_range(0, 99) < ready_pct);
    end

    function automatic logic [62:0] pack_coefs(int b0, int a1, int a2);
        logic [20:0] f0, f1, f2;
        f0 = b0[20:0];
        f1 = a1[20:0];
        f2 = a2[20:0];
        return {f2, f1, f0};
    endfunction

    task automatic write_reg(t_cfg_idx idx, logic [62:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        cfg_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // hold the request until taken; keep valid high inside a burst
    task automatic send(logic signed [23:0] s, logic flush);
        if (burst_left == 0) begin
            smp_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 40)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? 200 : $urandom_range(1, 12);
        end
        smp_ch.valid  <= 1'b1;
        smp_ch.sample <= s;
        smp_ch.flush  <= flush;
        @(posedge i_clk);
        while (!smp_ch.ready) @(posedge i_clk);
        burst_left--;
    endtask

    task automatic drain();
        smp_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    function automatic logic [62:0] pick_coefs(int band);
        case ($urandom_range(0, 5))
            0: return 63'({$urandom(), $urandom()});
            1: return '1;
            2: return '0;
            default: begin
                case (band)
                    0: return pack_coefs(17695, -299630, 108214);
                    1: return pack_coefs(52429, -314573, 157286);
                    default: return pack_coefs(157286, -298844, 107479);
                endcase
            end
        endcase
    endfunction

    function automatic logic [23:0] pick_sample();
        case ($urandom_range(0, 7))
            0: return 24'h7fffff;
            1: return 24'h800000;
            2: return 24'($signed($urandom_range(0, 4000)) - 2000);
            default: return 24'($urandom());
        endcase
    endfunction

    initial begin
        int hop;
        cycle_count   = 0;
        burst_left    = 0;
        ready_pct     = 100;
        i_rst_n       = 1'b0;
        smp_ch.valid  = 1'b0;
        smp_ch.sample = '0;
        smp_ch.flush  = 1'b0;
        cfg_ch.valid  = 1'b0;
        cfg_ch.index  = CFG_LOW;
        cfg_ch.data   = '0;
        res_ch.ready  = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // flush on an empty hop gives nothing; then a partial hop at reset settings
        send(24'h000000, 1'b1);
        send(24'h7fffff, 1'b0);
        send(24'h800000, 1'b0);
        send(24'h000001, 1'b0);
        send(24'h000000, 1'b1);
        send(24'h000000, 1'b1);
        drain();

        // full-scale negative hop saturates the level
        write_reg(CFG_LOW, pack_coefs(17695, -299630, 108214));
        write_reg(CFG_MID, pack_coefs(52429, -314573, 157286));
        write_reg(CFG_HIGH, pack_coefs(157286, -298844, 107479));
        write_reg(CFG_HOP, 63'd4);
        repeat (4) send(24'h800000, 1'b0);
        drain();

        // hop length zero: every sample ends a hop; unstable filters saturate
        write_reg(CFG_HOP, 63'd0);
        write_reg(CFG_LOW, '1);
        write_reg(CFG_HIGH, pack_coefs(-1048576, -1048576, 1048575));
        send(24'h7fffff, 1'b0);
        send(24'h800000, 1'b0);
        send(24'h7fffff, 1'b0);
        drain();

        // lower the hop length below the count
        write_reg(CFG_HOP, 63'd16);
        repeat (6) send(24'($urandom()), 1'b0);
        drain();
        write_reg(CFG_HOP, 63'd4);
        send(24'h123456, 1'b0);
        drain();

        for (int phase = 0; phase < 9; phase++) begin
            write_reg(CFG_LOW, pick_coefs(0));
            write_reg(CFG_MID, pick_coefs(1));
            write_reg(CFG_HIGH, pick_coefs(2));
            case (phase)
                0: hop = 1;
                3: hop = 4095;
                5: hop = 160;
                default: hop = $urandom_range(2, 40);
            endcase
            write_reg(CFG_HOP, 63'(hop));
            for (int n = 0; n < 150; n++) begin
                send(pick_sample(), $urandom_range(0, 24) == 0);
            end
            send(24'h000000, 1'b1);
            drain();
        end

        if (fail_count == 0 && pending == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
